// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands shared by the checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is high
`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/sbms_pkg.sv =====
package sbms_pkg;

  // Width of a stack number, fixed by the request format
  localparam int SID_W = 2;

  // Operation codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_POP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SID_W-1:0] stack_id;
    logic [31:0]      push_value;
  } req_t;

  typedef struct packed {
    logic [31:0] top_value;
    logic        stack_empty;
    status_t     status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PUSH_SCAN,
    S_POP_SCAN,
    S_TOP_RD,
    S_TOP_WAIT,
    S_RESULT
  } seq_state_t;

endpackage

// ===== hw/rtl/shared_buffer_multi_stack_top.sv =====
// Several LIFO stacks kept in one shared slot memory of CAPACITY words, each
// word holding a value, its owning stack and a free mark. One transaction is
// handled at a time. A push reads the memory one slot a cycle upward from the
// stack's top to the first free slot. A pop reads one slot a cycle downward
// from the old top to the next slot of the same stack. The single read port
// of the slot memory sets this pace. After reset a clearing pass marks every
// slot free, with the request side stalled. The next request is taken while a
// result still waits on the response side.
module shared_buffer_multi_stack_top
  import sbms_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int NUM_STACKS = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int WW = DATA_WIDTH + SID_W + 1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic          res_valid, res_take;
  rsp_t          res;

  sbms_ctrl #(
    .CAPACITY  (CAPACITY),
    .NUM_STACKS(NUM_STACKS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  sbms_slot_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(WW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Response register: loads when empty or being drained
  assign res_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      rsp <= res;
    end
  end

endmodule

// ===== hw/rtl/sbms_slot_ram.sv =====
module sbms_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 35
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sbms_ctrl.sv =====
module sbms_ctrl
  import sbms_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int NUM_STACKS = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  req_t                                   req,
  output logic                                   res_valid,
  output rsp_t                                   res,
  input  logic                                   res_take,
  output logic                                   ram_we,
  output logic [$clog2(CAPACITY)-1:0]            ram_waddr,
  output logic [DATA_WIDTH+SID_W:0]              ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]            ram_raddr,
  input  logic [DATA_WIDTH+SID_W:0]              ram_rdata
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int TW  = $clog2(CAPACITY + 1);
  localparam int SIW = $clog2(NUM_STACKS);
  localparam int WW  = DATA_WIDTH + SID_W + 1;

  seq_state_t state, state_next;

  // Latched transaction
  logic [1:0]            act;
  logic [SID_W-1:0]      sid;
  logic [DATA_WIDTH-1:0] val;

  // Scan pointer: next address up for push, next address plus one for pop
  logic [TW-1:0] ptr, ptr_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;

  logic [TW-1:0] tops [NUM_STACKS];
  logic          top_we;
  logic [TW-1:0] top_wval;

  logic [DATA_WIDTH-1:0] res_value, res_value_next;
  logic                  res_empty, res_empty_next;
  status_t               res_status, res_status_next;

  logic                  sid_ok;
  logic [SIW-1:0]        sid_idx;
  logic [TW-1:0]         cur_tp;
  logic [AW-1:0]         top_slot;
  logic                  rd_free;
  logic [SID_W-1:0]      rd_owner;
  logic [DATA_WIDTH-1:0] rd_value;
  logic                  is_push, is_pop;
  logic                  push_hit, pop_at_top, pop_hit;
  logic [AW-1:0]         down_addr;

  // Decode of the latched transaction and of the returning slot word
  assign sid_ok     = (32'(sid) < NUM_STACKS);
  assign sid_idx    = SIW'(sid);
  assign cur_tp     = sid_ok ? tops[sid_idx] : '0;
  assign top_slot   = AW'(cur_tp - TW'(1));
  assign rd_free    = ram_rdata[0];
  assign rd_owner   = ram_rdata[SID_W:1];
  assign rd_value   = ram_rdata[WW-1:SID_W+1];
  assign is_push    = (act == ACT_PUSH);
  assign is_pop     = (act == ACT_POP);
  assign push_hit   = pend && rd_free;
  assign pop_at_top = pend && (pend_addr == top_slot);
  assign pop_hit    = pend && !pop_at_top && (rd_owner == sid);
  assign down_addr  = AW'(ptr - TW'(1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (ptr == TW'(CAPACITY - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!sid_ok)                state_next = S_RESULT;
        else if (is_push)           state_next = S_PUSH_SCAN;
        else if (cur_tp == '0)      state_next = S_RESULT;
        else if (is_pop)            state_next = S_POP_SCAN;
        else                        state_next = S_TOP_RD;
      end
      S_PUSH_SCAN: begin
        if (push_hit) begin
          state_next = S_RESULT;
        end else if (ptr == TW'(CAPACITY)) begin
          state_next = (cur_tp == '0) ? S_RESULT : S_TOP_RD;
        end
      end
      S_POP_SCAN: begin
        if (pop_hit || ptr == '0) state_next = S_RESULT;
      end
      S_TOP_RD:   state_next = S_TOP_WAIT;
      S_TOP_WAIT: state_next = S_RESULT;
      S_RESULT: begin
        if (res_take) state_next = S_IDLE;
      end
      default:    state_next = S_CLEAR;
    endcase
  end

  // Memory accesses, scan pointer, stack tops and result
  always_comb begin
    req_stall       = 1'b1;
    ram_we          = 1'b0;
    ram_waddr       = pend_addr;
    ram_wdata       = {val, sid, 1'b0};
    ram_raddr       = ptr[AW-1:0];
    ptr_next        = ptr;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    top_we          = 1'b0;
    top_wval        = '0;
    res_value_next  = res_value;
    res_empty_next  = res_empty;
    res_status_next = res_status;
    case (state)
      S_CLEAR: begin
        // Mark every slot free, one per cycle
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = WW'(1);
        ptr_next  = ptr + TW'(1);
      end
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_DISPATCH: begin
        pend_next       = 1'b0;
        res_value_next  = '0;
        res_empty_next  = 1'b1;
        res_status_next = ST_OK;
        ptr_next        = cur_tp;
        if (!sid_ok) begin
          res_status_next = is_push ? ST_FULL : ST_UNDER;
        end else if (!is_push && cur_tp == '0) begin
          res_status_next = ST_UNDER;
        end
      end
      S_PUSH_SCAN: begin
        // Reads go out one a cycle; the word checked is the one read at pend_addr
        if (push_hit) begin
          ram_we          = 1'b1;
          top_we          = 1'b1;
          top_wval        = TW'(pend_addr) + TW'(1);
          res_value_next  = val;
          res_empty_next  = 1'b0;
        end else if (ptr == TW'(CAPACITY)) begin
          res_status_next = ST_FULL;
        end else begin
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
          ptr_next       = ptr + TW'(1);
        end
      end
      S_POP_SCAN: begin
        // First word back is the old top: write it back freed
        if (pop_at_top) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_value, rd_owner, 1'b1};
        end
        if (pop_hit) begin
          top_we         = 1'b1;
          top_wval       = TW'(pend_addr) + TW'(1);
          res_value_next = rd_value;
          res_empty_next = 1'b0;
        end else if (ptr == '0) begin
          top_we = 1'b1;
        end else begin
          ram_raddr      = down_addr;
          pend_next      = 1'b1;
          pend_addr_next = down_addr;
          ptr_next       = ptr - TW'(1);
        end
      end
      S_TOP_RD: begin
        ram_raddr = top_slot;
      end
      S_TOP_WAIT: begin
        res_value_next = rd_value;
        res_empty_next = 1'b0;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (state == S_RESULT);
  assign res       = '{top_value: 32'(res_value), stack_empty: res_empty, status: res_status};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      pend  <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        tops[s] <= '0;
      end
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      pend  <= pend_next;
      if (top_we) begin
        tops[sid_idx] <= top_wval;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      act <= req.action;
      sid <= req.stack_id;
      val <= DATA_WIDTH'(req.push_value);
    end
    pend_addr  <= pend_addr_next;
    res_value  <= res_value_next;
    res_empty  <= res_empty_next;
    res_status <= res_status_next;
  end

endmodule

// ===== hw/rtl/sbms_checker.sv =====
`include "assert_macros.svh"

module sbms_checker
  import sbms_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response stays put
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // One transaction in flight: the request side stalls right after acceptance
  `ASSERT_NXT(a_one_at_a_time, clk, rst, req_valid && !req_stall, req_stall)

  // Underflow is only reported for an empty stack
  `ASSERT_IMP(a_under_empty, clk, rst, rsp_valid && rsp.status == ST_UNDER, rsp.stack_empty)

  // An empty stack shows a zero top value
  `ASSERT_IMP(a_empty_zero, clk, rst, rsp_valid && rsp.stack_empty, rsp.top_value == 32'd0)

endmodule

bind shared_buffer_multi_stack_top sbms_checker u_sbms_checker (.*);

// ===== bench/tb_shared_buffer_multi_stack_top.sv =====
module tb_shared_buffer_multi_stack_top;
  import sbms_pkg::*;

  localparam int DEPTH = 64;
  localparam int NSTK = 4;
  localparam int WAIT_TAIL = DEPTH + 8;
  localparam int RAND_BLOCKS = 10;
  localparam int BLOCK_LEN = 150;
  localparam int DIR_ROWS = 24;

  // Spare operation code, handled by the block as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  shared_buffer_multi_stack_top #(
    .CAPACITY(DEPTH),
    .NUM_STACKS(NSTK),
    .DATA_WIDTH(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Shadow copy of the shared slot memory and the per-stack tops
  logic [31:0] slot_val [DEPTH];
  logic [1:0] slot_own [DEPTH];
  bit slot_is_free [DEPTH];
  int unsigned top_p1 [NSTK];

  rsp_t awaited_answers [$];
  int mismatches = 0;
  int n_full = 0;
  int n_under = 0;
  int n_pushed = 0;
  int n_random = 0;
  bit gap_off = 1'b0;
  bit stall_off = 1'b0;

  // Directed stimulus: one row per operation, repeated reps times with the
  // value stepping by one; typed rows carry their own expected answer
  typedef struct packed {
    logic [1:0] action;
    logic [1:0] sid;
    logic [31:0] value;
    int reps;
    bit typed;
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // all stacks empty: query, pop and the spare code underflow
    '{ACT_QUERY, 2'd0, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    '{ACT_POP, 2'd1, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    '{ACT_SPARE, 2'd2, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    // value extremes, interleaved owners
    '{ACT_PUSH, 2'd0, 32'h0, 1, 1'b1, '{32'h0, 1'b0, ST_OK}},
    '{ACT_PUSH, 2'd1, 32'hFFFF_FFFF, 1, 1'b1, '{32'hFFFF_FFFF, 1'b0, ST_OK}},
    '{ACT_PUSH, 2'd2, 32'hA5A5_A5A5, 1, 1'b0, '0},
    '{ACT_PUSH, 2'd0, 32'h5A5A_5A5A, 1, 1'b0, '0},
    '{ACT_QUERY, 2'd0, 32'hDEAD_BEEF, 1, 1'b0, '0},
    '{ACT_POP, 2'd1, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_OK}},
    // pop scans down past other owners
    '{ACT_POP, 2'd0, 32'h0, 1, 1'b0, '0},
    // fill every free slot, then refused pushes
    '{ACT_PUSH, 2'd3, 32'h3000_0000, 62, 1'b0, '0},
    '{ACT_PUSH, 2'd3, 32'hC0FF_EE00, 1, 1'b1, '{32'h3000_003D, 1'b0, ST_FULL}},
    '{ACT_PUSH, 2'd0, 32'h0, 1, 1'b1, '{32'h0, 1'b0, ST_FULL}},
    '{ACT_PUSH, 2'd2, 32'hFFFF_FFFF, 1, 1'b1, '{32'hA5A5_A5A5, 1'b0, ST_FULL}},
    '{ACT_QUERY, 2'd1, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    // drain
    '{ACT_POP, 2'd3, 32'h0, 62, 1'b0, '0},
    '{ACT_POP, 2'd3, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    '{ACT_QUERY, 2'd3, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    '{ACT_PUSH, 2'd1, 32'h1234_5678, 1, 1'b0, '0},
    '{ACT_POP, 2'd2, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_OK}},
    '{ACT_POP, 2'd0, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_OK}},
    '{ACT_POP, 2'd0, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_UNDER}},
    '{ACT_SPARE, 2'd1, 32'hFFFF_FFFF, 1, 1'b0, '0},
    '{ACT_POP, 2'd1, 32'h0, 1, 1'b1, '{32'h0, 1'b1, ST_OK}}
  };

  // Applies one transaction to the shadow memory and returns its answer
  function automatic rsp_t apply_stack_op(req_t r);
    rsp_t res;
    int unsigned idx;
    int unsigned sid;
    sid = 32'(r.stack_id);
    res.status = ST_OK;
    case (r.action)
      ACT_PUSH: begin
        idx = top_p1[sid];
        while (idx < DEPTH && !slot_is_free[idx]) idx++;
        if (idx >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot_val[idx] = r.push_value;
          slot_own[idx] = r.stack_id;
          slot_is_free[idx] = 1'b0;
          top_p1[sid] = idx + 1;
          n_pushed++;
        end
      end
      ACT_POP: begin
        if (top_p1[sid] == 0) begin
          res.status = ST_UNDER;
        end else begin
          idx = top_p1[sid] - 1;
          slot_is_free[idx] = 1'b1;
          // nearest lower slot last owned by this stack
          while (idx > 0 && slot_own[idx-1] != r.stack_id) idx--;
          top_p1[sid] = idx;
        end
      end
      default: begin
        if (top_p1[sid] == 0) res.status = ST_UNDER;
      end
    endcase
    if (top_p1[sid] != 0) begin
      res.top_value = slot_val[top_p1[sid]-1];
      res.stack_empty = 1'b0;
    end else begin
      res.top_value = '0;
      res.stack_empty = 1'b1;
    end
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_UNDER) n_under++;
    return res;
  endfunction

  // Presents one transaction after a random gap and logs its expected answer
  task automatic issue_op(input req_t r, input bit typed, input rsp_t want);
    int gap;
    rsp_t model_rsp;
    gap = gap_off ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    model_rsp = apply_stack_op(r);
    awaited_answers = {awaited_answers, (typed ? want : model_rsp)};
  endtask

  // Response side stall pattern
  initial begin
    int hold;
    wait (rst === 1'b0);
    forever begin
      hold = stall_off ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Answer checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: answer with none awaited: top %h empty %0d status %0d",
                 $time, rsp.top_value, rsp.stack_empty, rsp.status);
        mismatches++;
      end else begin
        want = awaited_answers.pop_front();
        if (rsp.top_value !== want.top_value) begin
          $display("%0t: top_value expected %h actual %h",
                   $time, want.top_value, rsp.top_value);
          mismatches++;
        end
        if (rsp.stack_empty !== want.stack_empty) begin
          $display("%0t: stack_empty expected %0d actual %0d",
                   $time, want.stack_empty, rsp.stack_empty);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp.status);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    req_t r;
    int push_pct;
    int roll;
    bit focus;
    logic [1:0] focus_sid;
    int drain;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_val[i] = '0;
      slot_own[i] = '0;
      slot_is_free[i] = 1'b1;
    end
    for (int s = 0; s < NSTK; s++) top_p1[s] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        r.action = dir_tab[i].action;
        r.stack_id = dir_tab[i].sid;
        r.push_value = dir_tab[i].value + k;
        issue_op(r, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random blocks, each leaning towards filling, draining or neither
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      focus = ($urandom_range(0, 2) == 0);
      focus_sid = 2'($urandom_range(0, NSTK - 1));
      gap_off = ($urandom_range(0, 3) == 0);
      stall_off = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BLOCK_LEN; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          r.action = ACT_PUSH;
        end else begin
          roll = $urandom_range(0, 9);
          r.action = (roll < 7) ? ACT_POP : (roll < 9) ? ACT_QUERY : ACT_SPARE;
        end
        if (focus && $urandom_range(0, 3) != 0) r.stack_id = focus_sid;
        else r.stack_id = 2'($urandom_range(0, NSTK - 1));
        case ($urandom_range(0, 7))
          0: r.push_value = 32'h0;
          1: r.push_value = 32'hFFFF_FFFF;
          default: r.push_value = $urandom;
        endcase
        issue_op(r, 1'b0, '0);
        n_random++;
      end
    end
    req_valid <= 1'b0;

    // let outstanding answers arrive, then a tail for stray ones
    drain = 0;
    while (awaited_answers.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (WAIT_TAIL) @(posedge clk);

    $display("Directed table plus %0d random transactions: %0d pushes stored,",
             n_random, n_pushed);
    $display("%0d pushes refused as full, %0d underflow answers.", n_full, n_under);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d answers never arrived",
               mismatches, awaited_answers.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d answers outstanding", awaited_answers.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
